// ===== hw/rtl/mi4c_pkg.sv =====
// ============================================================================
// mi4c_pkg
// Shared constants, datapath operation codes and the controller/datapath
// command and status structs of the 4x4 matrix inverse block.
// ============================================================================
package mi4c_pkg;

  // Default element format: signed Q16.16
  localparam int ELEMENT_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF    = 16;

  // Matrix geometry
  localparam int DIM       = 4;
  localparam int ADDR_BITS = 4;

  // Datapath operation codes
  localparam logic [3:0] OP_NONE     = 4'd0;
  localparam logic [3:0] OP_MUL1     = 4'd1;  // prod <= a*b
  localparam logic [3:0] OP_MUL2     = 4'd2;  // t <= prod, prod <= a*b
  localparam logic [3:0] OP_TLOAD    = 4'd3;  // mcand <= t - prod, mplier <= a
  localparam logic [3:0] OP_SER_COF  = 4'd4;  // one shift-add step into cofactor
  localparam logic [3:0] OP_DLOAD    = 4'd5;  // mcand <= cofactor, mplier <= a
  localparam logic [3:0] OP_SER_DET  = 4'd6;  // one shift-add step into determinant
  localparam logic [3:0] OP_DMAG     = 4'd7;  // latch |det|
  localparam logic [3:0] OP_DIV_INIT = 4'd8;  // load divider from cofactor
  localparam logic [3:0] OP_DIV_STEP = 4'd9;  // one restoring division step
  localparam logic [3:0] OP_RESULT   = 4'd10; // saturate quotient into output
  localparam logic [3:0] OP_SINGULAR = 4'd11; // singular marker into output

  // Controller to datapath
  typedef struct packed {
    logic                 wr_en;
    logic [ADDR_BITS-1:0] wr_addr;
    logic [ADDR_BITS-1:0] rd_addr0;
    logic [ADDR_BITS-1:0] rd_addr1;
    logic [3:0]           op;
    logic                 sub;     // accumulate with minus sign
    logic                 msb;     // multiplier sign bit step
    logic                 last;    // final result of the run
    logic                 clr_cof;
    logic                 clr_det;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic det_zero;
  } dp_stat_t;

endpackage

// ===== hw/rtl/mi4c_ram.sv =====
// ============================================================================
// mi4c_ram
// Generic RAM: one write port, two read ports, registered read data.
// ============================================================================
module mi4c_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// ===== hw/rtl/mi4c_dp.sv =====
// ============================================================================
// mi4c_dp
// Datapath: matrix store, W x W product for 2x2 minors, shift-add
// multiply-accumulate for cofactors and determinant, restoring divider and
// the saturating output register.
// ============================================================================
module mi4c_dp #(
  parameter int ELEMENT_BITS = mi4c_pkg::ELEMENT_BITS_DEF,
  parameter int FRAC_BITS    = mi4c_pkg::FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic [ELEMENT_BITS-1:0] element,
  input  mi4c_pkg::dp_cmd_t       cmd,
  output mi4c_pkg::dp_stat_t      stat,
  output logic [ELEMENT_BITS-1:0] inverse_element,
  output logic                    singular,
  output logic                    last_of_run
);

  localparam int W   = ELEMENT_BITS;
  localparam int TW  = 2 * W + 1;         // 2x2 minor
  localparam int DW  = 4 * W + 5;         // determinant / accumulators
  localparam int CMW = 3 * W + 1;         // cofactor magnitude
  localparam int NB  = CMW + 2 * FRAC_BITS; // dividend bits

  logic [W-1:0]          rd0, rd1;
  logic signed [2*W-1:0] mul;
  logic signed [2*W-1:0] prod;
  logic [TW-1:0]         t;
  logic [TW-1:0]         t_diff;
  logic [W-1:0]          mplier;
  logic [DW-1:0]         mcand;
  logic [DW-1:0]         cof, det, dmag;
  logic                  qneg;
  logic [NB-1:0]         dvd;
  logic [DW-1:0]         rem;
  logic [W-1:0]          q;
  logic                  big;

  logic [DW-1:0] term, acc_in, acc_out, cof_abs;
  logic [DW:0]   rsh, rdiff;
  logic          ge, dosub;
  logic [W-1:0]  sbit, maxpos, mag, res;

  // Matrix store
  mi4c_ram #(.WIDTH(W), .DEPTH(mi4c_pkg::DIM * mi4c_pkg::DIM)) u_ram (
    .clk    (clk),
    .we     (cmd.wr_en),
    .waddr  (cmd.wr_addr),
    .wdata  (element),
    .raddr0 (cmd.rd_addr0),
    .raddr1 (cmd.rd_addr1),
    .rdata0 (rd0),
    .rdata1 (rd1)
  );

  // Element product and minor difference
  assign mul    = $signed(rd0) * $signed(rd1);
  assign t_diff = t - {prod[2*W-1], prod};

  // Shift-add step: sign bit of the multiplier has negative weight
  assign term    = mplier[0] ? mcand : '0;
  assign dosub   = cmd.sub ^ cmd.msb;
  assign acc_in  = (cmd.op == mi4c_pkg::OP_SER_COF) ? cof : det;
  assign acc_out = dosub ? (acc_in - term) : (acc_in + term);

  // Divider step
  assign cof_abs = cof[DW-1] ? (~cof + 1'b1) : cof;
  assign rsh     = {rem, dvd[NB-1]};
  assign rdiff   = rsh - {1'b0, dmag};
  assign ge      = (rsh >= {1'b0, dmag});

  // Saturation to the signed element range
  assign sbit   = {1'b1, {(W-1){1'b0}}};
  assign maxpos = ~sbit;
  always_comb begin
    mag = q;
    if (qneg) begin
      if (big || (q > sbit)) begin
        mag = sbit;
      end
      res = '0 - mag;
    end else begin
      res = (big || q[W-1]) ? maxpos : q;
    end
  end

  assign stat.det_zero = (det == '0);

  // Operation execution
  always_ff @(posedge clk) begin
    if (cmd.clr_cof) begin
      cof <= '0;
    end
    if (cmd.clr_det) begin
      det <= '0;
    end
    case (cmd.op)
      mi4c_pkg::OP_MUL1: begin
        prod <= mul;
      end
      mi4c_pkg::OP_MUL2: begin
        t    <= {prod[2*W-1], prod};
        prod <= mul;
      end
      mi4c_pkg::OP_TLOAD: begin
        mcand  <= {{(DW-TW){t_diff[TW-1]}}, t_diff};
        mplier <= rd0;
      end
      mi4c_pkg::OP_DLOAD: begin
        mcand  <= cof;
        mplier <= rd0;
      end
      mi4c_pkg::OP_SER_COF: begin
        cof    <= acc_out;
        mcand  <= {mcand[DW-2:0], 1'b0};
        mplier <= {1'b0, mplier[W-1:1]};
      end
      mi4c_pkg::OP_SER_DET: begin
        det    <= acc_out;
        mcand  <= {mcand[DW-2:0], 1'b0};
        mplier <= {1'b0, mplier[W-1:1]};
      end
      mi4c_pkg::OP_DMAG: begin
        dmag <= det[DW-1] ? (~det + 1'b1) : det;
      end
      mi4c_pkg::OP_DIV_INIT: begin
        dvd  <= {cof_abs[CMW-1:0], {(2*FRAC_BITS){1'b0}}};
        rem  <= '0;
        q    <= '0;
        big  <= 1'b0;
        qneg <= cof[DW-1] ^ det[DW-1];
      end
      mi4c_pkg::OP_DIV_STEP: begin
        rem <= ge ? rdiff[DW-1:0] : rsh[DW-1:0];
        dvd <= {dvd[NB-2:0], 1'b0};
        big <= big | q[W-1];
        q   <= {q[W-2:0], ge};
      end
      mi4c_pkg::OP_RESULT: begin
        inverse_element <= res;
        singular        <= 1'b0;
        last_of_run     <= cmd.last;
      end
      mi4c_pkg::OP_SINGULAR: begin
        inverse_element <= '0;
        singular        <= 1'b1;
        last_of_run     <= 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hw/rtl/mi4c_ctrl.sv =====
// ============================================================================
// mi4c_ctrl
// Controller: load sequencing, cofactor address generation, serial and
// divider step counting, result handshake.
// ============================================================================
module mi4c_ctrl #(
  parameter int ELEMENT_BITS = mi4c_pkg::ELEMENT_BITS_DEF,
  parameter int FRAC_BITS    = mi4c_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  output mi4c_pkg::dp_cmd_t  cmd,
  input  mi4c_pkg::dp_stat_t stat
);

  localparam int NB   = 3 * ELEMENT_BITS + 1 + 2 * FRAC_BITS;
  localparam int CNTW = $clog2(NB);

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_MA    = 4'd1;
  localparam logic [3:0] S_MB    = 4'd2;
  localparam logic [3:0] S_MC    = 4'd3;
  localparam logic [3:0] S_MD    = 4'd4;
  localparam logic [3:0] S_SER   = 4'd5;
  localparam logic [3:0] S_DA    = 4'd6;
  localparam logic [3:0] S_DB    = 4'd7;
  localparam logic [3:0] S_DSER  = 4'd8;
  localparam logic [3:0] S_CHK   = 4'd9;
  localparam logic [3:0] S_SING  = 4'd10;
  localparam logic [3:0] S_DINIT = 4'd11;
  localparam logic [3:0] S_DIV   = 4'd12;
  localparam logic [3:0] S_RES   = 4'd13;
  localparam logic [3:0] S_EMIT  = 4'd14;

  logic [3:0]      state, state_next;
  logic [CNTW-1:0] cnt, cnt_next;
  logic [3:0]      idx, idx_next;
  logic [1:0]      j, j_next;
  logic            inv, inv_next;
  logic            fin, fin_next;
  logic [3:0]      lcnt, lcnt_next;

  logic [1:0] crow, ccol, a_l, b_l;
  logic [1:0] sr0, sr1, sr2, sc_a, sc_b, sc_j;
  logic       ser_last, div_last;

  // Index of submatrix line k after removing line x
  function automatic logic [1:0] skip(input logic [1:0] k, input logic [1:0] x);
    skip = (k < x) ? k : (k + 2'd1);
  endfunction

  // Cofactor being formed: row 0 during determinant, transposed during inverse
  assign crow = inv ? idx[1:0] : 2'd0;
  assign ccol = inv ? idx[3:2] : idx[1:0];
  assign a_l  = (j == 2'd0) ? 2'd1 : 2'd0;
  assign b_l  = (j == 2'd2) ? 2'd1 : 2'd2;
  assign sr0  = skip(2'd0, crow);
  assign sr1  = skip(2'd1, crow);
  assign sr2  = skip(2'd2, crow);
  assign sc_a = skip(a_l, ccol);
  assign sc_b = skip(b_l, ccol);
  assign sc_j = skip(j, ccol);

  assign ser_last = (cnt == CNTW'(ELEMENT_BITS - 1));
  assign div_last = (cnt == CNTW'(NB - 1));

  assign s_tready = (state == S_LOAD);
  assign m_tvalid = (state == S_EMIT);

  // Next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    idx_next   = idx;
    j_next     = j;
    inv_next   = inv;
    fin_next   = fin;
    lcnt_next  = lcnt;
    cmd        = '0;
    cmd.op     = mi4c_pkg::OP_NONE;
    case (state)
      S_LOAD: begin
        cmd.wr_en   = s_tvalid;
        cmd.wr_addr = lcnt;
        if (s_tvalid) begin
          lcnt_next = lcnt + 4'd1;
          if (lcnt == 4'd15) begin
            cmd.clr_det = 1'b1;
            state_next  = S_MA;
            idx_next    = '0;
            j_next      = '0;
            inv_next    = 1'b0;
            fin_next    = 1'b0;
          end
        end
      end
      S_MA: begin
        cmd.rd_addr0 = {sr1, sc_a};
        cmd.rd_addr1 = {sr2, sc_b};
        cmd.clr_cof  = (j == 2'd0);
        state_next   = S_MB;
      end
      S_MB: begin
        cmd.op       = mi4c_pkg::OP_MUL1;
        cmd.rd_addr0 = {sr1, sc_b};
        cmd.rd_addr1 = {sr2, sc_a};
        state_next   = S_MC;
      end
      S_MC: begin
        cmd.op       = mi4c_pkg::OP_MUL2;
        cmd.rd_addr0 = {sr0, sc_j};
        state_next   = S_MD;
      end
      S_MD: begin
        cmd.op     = mi4c_pkg::OP_TLOAD;
        cnt_next   = '0;
        state_next = S_SER;
      end
      S_SER: begin
        cmd.op  = mi4c_pkg::OP_SER_COF;
        cmd.sub = (j == 2'd1) ^ crow[0] ^ ccol[0];
        cmd.msb = ser_last;
        cnt_next = cnt + 1'b1;
        if (ser_last) begin
          if (j == 2'd2) begin
            j_next     = '0;
            state_next = inv ? S_DINIT : S_DA;
          end else begin
            j_next     = j + 2'd1;
            state_next = S_MA;
          end
        end
      end
      S_DA: begin
        cmd.rd_addr0 = {2'd0, idx[1:0]};
        state_next   = S_DB;
      end
      S_DB: begin
        cmd.op     = mi4c_pkg::OP_DLOAD;
        cnt_next   = '0;
        state_next = S_DSER;
      end
      S_DSER: begin
        cmd.op   = mi4c_pkg::OP_SER_DET;
        cmd.msb  = ser_last;
        cnt_next = cnt + 1'b1;
        if (ser_last) begin
          if (idx == 4'd3) begin
            state_next = S_CHK;
          end else begin
            idx_next   = idx + 4'd1;
            state_next = S_MA;
          end
        end
      end
      S_CHK: begin
        if (stat.det_zero) begin
          state_next = S_SING;
        end else begin
          cmd.op     = mi4c_pkg::OP_DMAG;
          idx_next   = '0;
          inv_next   = 1'b1;
          state_next = S_MA;
        end
      end
      S_SING: begin
        cmd.op     = mi4c_pkg::OP_SINGULAR;
        fin_next   = 1'b1;
        state_next = S_EMIT;
      end
      S_DINIT: begin
        cmd.op     = mi4c_pkg::OP_DIV_INIT;
        cnt_next   = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op   = mi4c_pkg::OP_DIV_STEP;
        cnt_next = cnt + 1'b1;
        if (div_last) begin
          state_next = S_RES;
        end
      end
      S_RES: begin
        cmd.op     = mi4c_pkg::OP_RESULT;
        cmd.last   = (idx == 4'd15);
        fin_next   = (idx == 4'd15);
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (m_tready) begin
          if (fin) begin
            state_next = S_LOAD;
          end else begin
            idx_next   = idx + 4'd1;
            state_next = S_MA;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      cnt   <= '0;
      idx   <= '0;
      j     <= '0;
      inv   <= 1'b0;
      fin   <= 1'b0;
      lcnt  <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      idx   <= idx_next;
      j     <= j_next;
      inv   <= inv_next;
      fin   <= fin_next;
      lcnt  <= lcnt_next;
    end
  end

endmodule

// ===== hw/rtl/matrix_inverse_4x4_cofactor.sv =====
// ============================================================================
// matrix_inverse_4x4_cofactor
// 4x4 fixed-point matrix inverse by adjugate and determinant.
//
//   channel | dir | tdata                    | tuser    | tlast
//   s_      | in  | element                  | -        | -
//   m_      | out | inverse_element          | singular | last_of_run
//
// Loading accepts 16 elements per matrix. A cofactor is formed by shift-add
// multiply-accumulate over three 2x2 minors, one multiplier bit per cycle;
// the determinant accumulates four row-0 cofactors times their elements.
// Each inverse element then needs its cofactor and a restoring division
// over a 3W+1+2F bit dividend, the divider retiring one quotient bit per
// cycle, before the output handshake. Input is held off while busy.
// Reset is synchronous; it returns the block to loading a new matrix.
// ============================================================================
module matrix_inverse_4x4_cofactor #(
  parameter int ELEMENT_BITS = mi4c_pkg::ELEMENT_BITS_DEF,
  parameter int FRAC_BITS    = mi4c_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [((ELEMENT_BITS+7)/8)*8-1:0]     s_tdata,  // element
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [((ELEMENT_BITS+7)/8)*8-1:0]     m_tdata,  // inverse_element
  output logic [0:0]                            m_tuser,  // singular
  output logic                                  m_tlast   // last_of_run
);

  localparam int DATA_BITS = ((ELEMENT_BITS + 7) / 8) * 8;

  mi4c_pkg::dp_cmd_t       cmd;
  mi4c_pkg::dp_stat_t      stat;
  logic [ELEMENT_BITS-1:0] inverse_element;
  logic                    singular;

  mi4c_ctrl #(.ELEMENT_BITS(ELEMENT_BITS), .FRAC_BITS(FRAC_BITS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  mi4c_dp #(.ELEMENT_BITS(ELEMENT_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk             (clk),
    .element         (s_tdata[ELEMENT_BITS-1:0]),
    .cmd             (cmd),
    .stat            (stat),
    .inverse_element (inverse_element),
    .singular        (singular),
    .last_of_run     (m_tlast)
  );

  assign m_tdata    = DATA_BITS'(inverse_element);
  assign m_tuser[0] = singular;

endmodule

// ===== hw/rtl/mi4c_checker.sv =====
// ============================================================================
// mi4c_checker
// Port-level checks of the matrix inverse block, bound to the top level.
// ============================================================================
module mi4c_checker #(
  parameter int ELEMENT_BITS = mi4c_pkg::ELEMENT_BITS_DEF
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [((ELEMENT_BITS+7)/8)*8-1:0] m_tdata,
  input logic [0:0]                        m_tuser,
  input logic                              m_tlast
);

  // No element taken while a result is pending
  a_no_load_while_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input ready while result pending");

  // Singular marker is always the last transfer of the run
  a_sing_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> m_tlast)
    else $error("singular result without tlast");

  // Singular marker carries zero data
  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
    else $error("singular result with nonzero data");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("result changed under stall");

endmodule

bind matrix_inverse_4x4_cofactor mi4c_checker #(.ELEMENT_BITS(ELEMENT_BITS)) u_checker (.*);
